### rtl/stable_min_priority_queue_top_macros.svh
// Assertion macros for the stable minimum priority queue.
// Used by the top level only; needs clk_i and rst_ni in scope.
`ifndef STABLE_MIN_PRIORITY_QUEUE_TOP_MACROS_SVH
`define STABLE_MIN_PRIORITY_QUEUE_TOP_MACROS_SVH

// Property checked on every clock edge, ignored while in reset
`define SPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Property that must also hold while reset is applied
`define SPQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### rtl/spq_pkg.sv
// Package for the stable minimum priority queue: payload structs, codes,
// cell data types and default depth. No dependencies.
package spq_pkg;

  localparam int unsigned DefaultDepth = 16;
  localparam int unsigned DataW        = 32;
  localparam int unsigned FillW        = 5;

  typedef enum logic {
    CmdInsert = 1'b0,
    CmdRemove = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    StDone  = 2'd0,
    StEmpty = 2'd1,
    StFull  = 2'd2
  } status_e;

  // One input item
  typedef struct packed {
    cmd_e                    cmd;
    logic signed [DataW-1:0] item_value;
    logic signed [DataW-1:0] item_rank;
  } in_t;

  // One result item
  typedef struct packed {
    status_e                 status;
    logic signed [DataW-1:0] removed_value;
    logic signed [DataW-1:0] removed_rank;
    logic                    head_present;
    logic signed [DataW-1:0] head_value;
    logic signed [DataW-1:0] head_rank;
    logic [FillW-1:0]        fill;
  } out_t;

  // Contents of one cell of the sorted chain
  typedef struct packed {
    logic                    valid;
    logic signed [DataW-1:0] value;
    logic signed [DataW-1:0] rank;
  } cell_t;

  // Operation broadcast to every cell
  typedef struct packed {
    logic                    ins;
    logic                    rem;
    logic signed [DataW-1:0] value;
    logic signed [DataW-1:0] rank;
  } op_t;

endpackage

### rtl/stable_min_priority_queue_top.sv
// Stable minimum priority queue: a chain of spq_cell instances kept sorted
// by rank, plus fill count and result register.
// Depends on spq_pkg, spq_cell and stable_min_priority_queue_top_macros.svh.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o / in_i) carries an insert of a
//   value with its rank, or a remove of the head entry. Output channel
//   (out_valid_o / out_ready_i / out_o) returns one result per item: status,
//   removed entry, new head and fill level.
//   Entries of equal rank leave in arrival order.
//   The result is registered and presented in the cycle after the item's transfer.
//   Throughput: one item per cycle while the output is not stalled. Every
//   cell compares its rank with the new rank and shifts in the same cycle,
//   so the chain's work per item does not grow with the depth; the compare
//   in each cell and the shift to its neighbour set the path.
//   Stall: the result register holds while out_ready_i is low; a new item is
//   taken in the same cycle the held result is transferred.
//   Reset: all cells empty, fill zero, no result pending; no clearing pass.
//   Insert when full returns status full and drops the entry; remove when
//   empty returns status empty. Both leave the contents unchanged.
`include "stable_min_priority_queue_top_macros.svh"

module stable_min_priority_queue_top #(
  parameter int unsigned QueueDepth = spq_pkg::DefaultDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  spq_pkg::in_t  in_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output spq_pkg::out_t out_o
);

  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  spq_pkg::op_t   op;
  spq_pkg::cell_t cell_q [QueueDepth];
  spq_pkg::cell_t cell_d [QueueDepth];
  logic [QueueDepth-1:0] le;
  logic [QueueDepth-1:0] valid_vec;

  logic [CntW-1:0] count_q, count_d;
  logic            fire, full, empty;
  logic            out_valid_q, out_valid_d;
  spq_pkg::out_t   out_q, out_d;

  // Handshake
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign fire       = in_valid_i && in_ready_o;
  assign full       = (count_q == CntW'(QueueDepth));
  assign empty      = (count_q == '0);

  // Operation broadcast to the chain
  always_comb begin
    op.ins   = fire && (in_i.cmd == spq_pkg::CmdInsert) && !full;
    op.rem   = fire && (in_i.cmd == spq_pkg::CmdRemove) && !empty;
    op.value = in_i.item_value;
    op.rank  = in_i.item_rank;
  end

  // Chain of cells, head at index 0
  for (genvar i = 0; i < QueueDepth; i++) begin : g_cell
    spq_pkg::cell_t left, right;
    logic           left_le;

    if (i == 0) begin : g_head
      assign left    = '0;
      assign left_le = 1'b1;
    end else begin : g_body
      assign left    = cell_q[i-1];
      assign left_le = le[i-1];
    end

    if (i == QueueDepth - 1) begin : g_tail
      assign right = '0;
    end else begin : g_inner
      assign right = cell_q[i+1];
    end

    spq_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .op_i      (op),
      .left_i    (left),
      .left_le_i (left_le),
      .right_i   (right),
      .le_o      (le[i]),
      .q_o       (cell_q[i]),
      .d_o       (cell_d[i])
    );

    assign valid_vec[i] = cell_q[i].valid;
  end

  // Fill count
  always_comb begin
    count_d = count_q;
    if (op.ins) begin
      count_d = count_q + CntW'(1);
    end else if (op.rem) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // Result built from the chain's current and next state
  always_comb begin
    out_d               = '0;
    out_d.status        = spq_pkg::StDone;
    if ((in_i.cmd == spq_pkg::CmdInsert) && full) begin
      out_d.status = spq_pkg::StFull;
    end else if ((in_i.cmd == spq_pkg::CmdRemove) && empty) begin
      out_d.status = spq_pkg::StEmpty;
    end
    if (op.rem) begin
      out_d.removed_value = cell_q[0].value;
      out_d.removed_rank  = cell_q[0].rank;
    end
    out_d.head_present = cell_d[0].valid;
    if (cell_d[0].valid) begin
      out_d.head_value = cell_d[0].value;
      out_d.head_rank  = cell_d[0].rank;
    end
    out_d.fill = spq_pkg::FillW'(count_d);
  end

  assign out_valid_d = fire || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload, no reset
  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // Checks
  `SPQ_ASSERT(a_count_matches_cells, ($countones(valid_vec) == count_q), "fill count differs from occupied cells")
  `SPQ_ASSERT_ALWAYS(a_cells_packed, (!rst_ni || (((valid_vec + 1'b1) & valid_vec) == '0)), "occupied cells not packed at head")
  `SPQ_ASSERT(a_head_sorted, (cell_q[1].valid |-> (cell_q[0].rank <= cell_q[1].rank)), "head rank above second rank")
  `SPQ_ASSERT(a_full_reported, ((fire && (in_i.cmd == spq_pkg::CmdInsert) && full) |=> (out_q.status == spq_pkg::StFull)), "insert into full queue not reported")
  `SPQ_ASSERT(a_full_unchanged, ((fire && (in_i.cmd == spq_pkg::CmdInsert) && full) |=> $stable(count_q)), "fill changed on rejected insert")

endmodule

### rtl/spq_cell.sv
// One cell of the sorted chain: holds one entry, takes a new entry, its
// left neighbour's entry or its right neighbour's entry. Depends on spq_pkg.
module spq_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  spq_pkg::op_t   op_i,
  input  spq_pkg::cell_t left_i,
  input  logic           left_le_i,
  input  spq_pkg::cell_t right_i,
  output logic           le_o,
  output spq_pkg::cell_t q_o,
  output spq_pkg::cell_t d_o
);

  spq_pkg::cell_t cell_q, cell_d;

  // Held entry ranks at or below the new rank: it stays put on insert
  assign le_o = cell_q.valid && (cell_q.rank <= op_i.rank);

  // Next contents
  always_comb begin
    cell_d = cell_q;
    if (op_i.ins) begin
      if (!le_o) begin
        if (left_le_i) begin
          cell_d.valid = 1'b1;
          cell_d.value = op_i.value;
          cell_d.rank  = op_i.rank;
        end else begin
          cell_d = left_i;
        end
      end
    end else if (op_i.rem) begin
      cell_d = right_i;
    end
  end

  // Cell register, cleared to empty on reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else begin
      cell_q <= cell_d;
    end
  end

  assign q_o = cell_q;
  assign d_o = cell_d;

endmodule
